@@ hw/rtl/jac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jac_pkg
// shared constants, types and helpers of the 3x3 jacobi eigen solver
// ----------------------------------------------------------------------------
package jac_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FW = 32;
   localparam int ROT_W = 8;
   localparam int THR_W = 31;
   localparam int CSR_W = 31;
   localparam int NLANE = 6;

   typedef enum logic [0:0] {
      CSR_MAX_ROT = 1'b0,
      CSR_THRESH  = 1'b1
   } csr_idx_type;

   // what one lane hands the merging stage
   typedef struct packed {
      logic [FW-1:0] mag;
   } lane_res_type;

   // pivot choice from the merging stage
   typedef struct packed {
      logic [1:0]    p;
      logic [1:0]    q;
      logic [FW-1:0] best;
   } pivot_type;

   function automatic logic [FW-1:0] mag32(input logic signed [FW-1:0] v);
      logic [FW:0] t;
      t = v[FW-1] ? (~{v[FW-1], v} + 33'd1) : {1'b0, v};
      return t[FW-1:0] | {FW{t[FW]}};
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/jac_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jac_lane
// magnitude of one off-diagonal element, registered
// ----------------------------------------------------------------------------
module jac_lane (
   input  wire logic                     clock,
   input  wire logic signed [jac_pkg::FW-1:0] elem,
   output jac_pkg::lane_res_type         res
);
   import jac_pkg::*;
   logic [FW-1:0] mag_ff;
   // unsigned magnitude: |-2^31| is 2^31 exactly
   always_ff @(posedge clock) begin
      mag_ff <= elem[FW-1] ? (~elem + 32'd1) : elem;
   end
   assign res.mag = mag_ff;
endmodule
`default_nettype wire

@@ hw/rtl/jac_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jac_merge
// picks the largest lane magnitude, first in row-major order on ties
// ----------------------------------------------------------------------------
module jac_merge (
   input  wire logic                  clock,
   input  jac_pkg::lane_res_type      lanes [jac_pkg::NLANE],
   output jac_pkg::pivot_type         pivot
);
   import jac_pkg::*;
   pivot_type pv_in, pv_ff;
   logic [1:0] lp [NLANE];
   logic [1:0] lq [NLANE];
   assign lp = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   assign lq = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
   always_comb begin
      pv_in = '0;
      for (int i = 0; i < NLANE; i++) begin
         if (lanes[i].mag > pv_in.best) begin
            pv_in.best = lanes[i].mag;
            pv_in.p = lp[i];
            pv_in.q = lq[i];
         end
      end
   end
   always_ff @(posedge clock) begin
      pv_ff <= pv_in;
   end
   assign pivot = pv_ff;
endmodule
`default_nettype wire

@@ hw/rtl/jac_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jac_sqrt
// bit-serial integer square root and restoring divider, shared unit
// ----------------------------------------------------------------------------
module jac_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        go,
   input  wire logic        div_mode,
   input  wire logic [63:0] arg_a,
   input  wire logic [63:0] arg_b,
   output logic             done,
   output logic [63:0]      result
);
   logic [63:0] x_ff, r_ff, b_ff, d_ff;
   logic [6:0]  n_ff;
   logic        run_ff, mode_ff, done_ff;
   logic [64:0] trial;
   logic [64:0] rem_sh;
   always_comb begin
      trial  = {1'b0, x_ff} - {1'b0, r_ff + b_ff};
      rem_sh = {r_ff, x_ff[63]};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            mode_ff <= div_mode;
            x_ff <= arg_a;
            d_ff <= arg_b;
            r_ff <= '0;
            b_ff <= 64'h4000_0000_0000_0000;
            n_ff <= div_mode ? 7'd64 : 7'd32;
         end else if (run_ff) begin
            if (mode_ff) begin
               // restoring division: r is remainder, x shifts into quotient
               if (rem_sh >= {1'b0, d_ff}) begin
                  r_ff <= 64'(rem_sh - {1'b0, d_ff});
                  x_ff <= {x_ff[62:0], 1'b1};
               end else begin
                  r_ff <= rem_sh[63:0];
                  x_ff <= {x_ff[62:0], 1'b0};
               end
            end else begin
               if (!trial[64]) begin
                  x_ff <= trial[63:0];
                  r_ff <= (r_ff >> 1) + b_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               b_ff <= b_ff >> 2;
            end
            n_ff <= n_ff - 7'd1;
            if (n_ff == 7'd1) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   assign done = done_ff;
   assign result = mode_ff ? x_ff : r_ff;
endmodule
`default_nettype wire

@@ hw/rtl/jacobi_eigen_3x3.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_eigen_3x3
// eigenvalues and eigenvectors of a symmetric 3x3 matrix by jacobi rotations
// ----------------------------------------------------------------------------
// One item (nine Q8.24 elements) is taken when start is high and busy low.
// Six lanes take the off-diagonal magnitudes and a merging stage picks the
// pivot; a shared bit-serial unit then does three square roots and one
// division, and a pair of multipliers walks the row, column and vector
// updates. Three results follow on consecutive cycles, each marked by
// rsp_valid for one cycle; the receiver cannot stall.
module jacobi_eigen_3x3 #(
   parameter int DATA_WIDTH = jac_pkg::DATA_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic signed [31:0] req_m00,
   input  wire logic signed [31:0] req_m01,
   input  wire logic signed [31:0] req_m02,
   input  wire logic signed [31:0] req_m10,
   input  wire logic signed [31:0] req_m11,
   input  wire logic signed [31:0] req_m12,
   input  wire logic signed [31:0] req_m20,
   input  wire logic signed [31:0] req_m21,
   input  wire logic signed [31:0] req_m22,
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [jac_pkg::CSR_W-1:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_column_index,
   output logic signed [31:0] rsp_eigen_value,
   output logic signed [31:0] rsp_vec_x,
   output logic signed [31:0] rsp_vec_y,
   output logic signed [31:0] rsp_vec_z,
   output logic        rsp_status,
   output logic        rsp_last
);
   import jac_pkg::*;
   localparam int EW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic signed [63:0] EHI = (64'sd1 <<< (EW - 1)) - 64'sd1;
   localparam logic signed [63:0] ELO = -EHI - 64'sd1;
   localparam logic signed [31:0] ONE = 32'(((64'sd1 <<< 24) > EHI) ? EHI : (64'sd1 <<< 24));

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_LANE  = 12'b000000000010,
      S_MERGE = 12'b000000000100,
      S_PICK  = 12'b000000001000,
      S_PREP  = 12'b000000010000,
      S_SQ1   = 12'b000000100000,
      S_DIV   = 12'b000001000000,
      S_SQ2   = 12'b000010000000,
      S_SQ3   = 12'b000100000000,
      S_COEF  = 12'b001000000000,
      S_UPD   = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type st_ff;
   logic [ROT_W-1:0] maxrot_ff, k_ff;
   logic [THR_W-1:0] thr_ff;
   logic signed [31:0] a_ff [3][3];
   logic signed [31:0] x_ff [3][3];
   logic [1:0] p_ff, q_ff, oc_ff;
   logic status_ff;
   logic [63:0] sa_ff, tb_ff;
   logic neg_ff;
   logic signed [31:0] sn_ff, cs_ff;
   logic signed [31:0] cc_ff, ss_ff, sc2_ff;
   logic [63:0] v_ff;
   logic [1:0] cstep_ff;
   logic [4:0] ustep_ff;
   logic signed [95:0] acc_ff;
   logic signed [31:0] na_ff [3][3];
   logic signed [31:0] nx_ff [3][3];

   // lanes and merge
   lane_res_type lanes [NLANE];
   pivot_type pivot;
   jac_lane u_l0 (.clock(clock), .elem(a_ff[0][1]), .res(lanes[0]));
   jac_lane u_l1 (.clock(clock), .elem(a_ff[0][2]), .res(lanes[1]));
   jac_lane u_l2 (.clock(clock), .elem(a_ff[1][0]), .res(lanes[2]));
   jac_lane u_l3 (.clock(clock), .elem(a_ff[1][2]), .res(lanes[3]));
   jac_lane u_l4 (.clock(clock), .elem(a_ff[2][0]), .res(lanes[4]));
   jac_lane u_l5 (.clock(clock), .elem(a_ff[2][1]), .res(lanes[5]));
   jac_merge u_merge (.clock(clock), .lanes(lanes), .pivot(pivot));

   // shared root / divide unit
   logic su_go, su_div, su_done;
   logic [63:0] su_a, su_b, su_res;
   jac_sqrt u_sqrt (
      .clock(clock), .reset(reset), .go(su_go), .div_mode(su_div),
      .arg_a(su_a), .arg_b(su_b), .done(su_done), .result(su_res)
   );

   function automatic logic signed [63:0] rnd30(input logic signed [95:0] v);
      logic [95:0] m;
      logic [95:0] r;
      m = v[95] ? 96'(-v) : 96'(v);
      r = (m + (96'd1 << 29)) >> 30;
      if (r > 96'h7FFF_FFFF_FFFF_FFFF) r = 96'h7FFF_FFFF_FFFF_FFFF;
      return v[95] ? -$signed(r[63:0]) : $signed(r[63:0]);
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [63:0] v);
      if (v > EHI) return EHI[31:0];
      if (v < ELO) return ELO[31:0];
      return v[31:0];
   endfunction

   // update sequencer: one product pair per step, multiplier inputs chosen here
   logic [1:0] rr;
   logic signed [31:0] ma, mb, mc, md;
   logic signed [63:0] prod_a, prod_b;
   assign rr = 2'(3 - p_ff - q_ff);
   always_comb begin
      ma = '0; mb = '0; mc = '0; md = '0;
      case (ustep_ff)
         5'd0:  begin ma = a_ff[p_ff][p_ff]; mb = cc_ff; mc = a_ff[q_ff][q_ff]; md = ss_ff; end
         5'd2:  begin ma = a_ff[p_ff][p_ff]; mb = ss_ff; mc = a_ff[q_ff][q_ff]; md = cc_ff; end
         5'd4:  begin ma = a_ff[p_ff][rr]; mb = cs_ff; mc = a_ff[q_ff][rr]; md = -sn_ff; end
         5'd5:  begin ma = a_ff[q_ff][rr]; mb = cs_ff; mc = a_ff[p_ff][rr]; md = sn_ff; end
         5'd6:  begin ma = a_ff[rr][p_ff]; mb = cs_ff; mc = a_ff[rr][q_ff]; md = -sn_ff; end
         5'd7:  begin ma = a_ff[rr][q_ff]; mb = cs_ff; mc = a_ff[rr][p_ff]; md = sn_ff; end
         5'd8, 5'd10, 5'd12: begin
            ma = x_ff[2'(ustep_ff[2:1] - 2'd0)][p_ff]; mb = cs_ff;
            mc = x_ff[2'(ustep_ff[2:1] - 2'd0)][q_ff]; md = -sn_ff;
         end
         5'd9, 5'd11, 5'd13: begin
            ma = x_ff[2'(ustep_ff[2:1] - 2'd0)][q_ff]; mb = cs_ff;
            mc = x_ff[2'(ustep_ff[2:1] - 2'd0)][p_ff]; md = sn_ff;
         end
         5'd1, 5'd3: begin ma = a_ff[p_ff][q_ff]; mb = sc2_ff; end
         default: ;
      endcase
   end
   logic signed [63:0] pa_ff, pb_ff;
   always_ff @(posedge clock) begin
      pa_ff <= ma * mb;
      pb_ff <= mc * md;
   end
   assign prod_a = pa_ff;
   assign prod_b = pb_ff;
   logic [4:0] wstep_ff;

   logic signed [31:0] ap, aq;
   assign ap = a_ff[p_ff][p_ff];
   assign aq = a_ff[q_ff][q_ff];
   logic signed [33:0] sv, tv;
   assign sv = -34'sd2 * 34'(a_ff[p_ff][q_ff]);
   assign tv = 34'(ap) - 34'(aq);

   assign busy = (st_ff != S_IDLE);
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         maxrot_ff <= 8'd20;
         thr_ff <= 31'd17;
         rsp_valid <= 1'b0;
         su_go <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         su_go <= 1'b0;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_MAX_ROT: maxrot_ff <= csr_wdata[ROT_W-1:0];
               CSR_THRESH:  thr_ff <= csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         unique case (st_ff)
            S_IDLE: if (start) begin
               a_ff <= '{'{sat(64'(req_m00)), sat(64'(req_m01)), sat(64'(req_m02))},
                         '{sat(64'(req_m10)), sat(64'(req_m11)), sat(64'(req_m12))},
                         '{sat(64'(req_m20)), sat(64'(req_m21)), sat(64'(req_m22))}};
               x_ff <= '{'{ONE, 32'sd0, 32'sd0}, '{32'sd0, ONE, 32'sd0},
                         '{32'sd0, 32'sd0, ONE}};
               k_ff <= '0;
               oc_ff <= 2'd0;
               status_ff <= 1'b1;
               st_ff <= S_LANE;
            end
            S_LANE: st_ff <= (k_ff < maxrot_ff) ? S_MERGE : S_OUT;
            // S_MERGE waits for the lane and merge registers to settle
            S_MERGE: st_ff <= S_PICK;
            S_PICK: begin
               oc_ff <= 2'd0;
               if (pivot.best == '0 || pivot.best < {1'b0, thr_ff}) begin
                  status_ff <= 1'b0;
                  st_ff <= S_OUT;
               end else begin
                  p_ff <= pivot.p;
                  q_ff <= pivot.q;
                  st_ff <= S_PREP;
               end
            end
            S_PREP: begin
               logic [63:0] s0, t0;
               s0 = sv[33] ? 64'(-sv) : 64'(sv);
               t0 = tv[33] ? 64'(-tv) : 64'(tv);
               // at most two halvings bring both below 2^31
               if (s0 >= 64'h8000_0000 || t0 >= 64'h8000_0000) begin
                  s0 = s0 >> 1; t0 = t0 >> 1;
               end
               if (s0 >= 64'h8000_0000 || t0 >= 64'h8000_0000) begin
                  s0 = s0 >> 1; t0 = t0 >> 1;
               end
               sa_ff <= 64'(s0[31:0]) * 64'(s0[31:0]);
               tb_ff <= t0;
               neg_ff <= (sv != 0) && (tv != 0) && (sv[33] != tv[33]);
               cstep_ff <= 2'd0;
               st_ff <= S_SQ1;
            end
            S_SQ1: begin
               if (cstep_ff == 2'd0) begin
                  su_a <= sa_ff + 64'(tb_ff[31:0]) * 64'(tb_ff[31:0]);
                  su_div <= 1'b0; su_go <= 1'b1; cstep_ff <= 2'd1;
               end else if (su_done) begin
                  su_a <= tb_ff << 30;
                  su_b <= (su_res == 0) ? 64'd1 : su_res;
                  su_div <= 1'b1; su_go <= 1'b1;
                  st_ff <= S_DIV;
               end
            end
            S_DIV: if (su_done) begin
               v_ff <= (su_res > (64'd1 << 30)) ? (64'd1 << 30) : su_res;
               cstep_ff <= 2'd0;
               st_ff <= S_SQ2;
            end
            S_SQ2: begin
               if (cstep_ff == 2'd0) begin
                  su_a <= ((64'd1 << 30) - v_ff) << 29;
                  su_div <= 1'b0; su_go <= 1'b1; cstep_ff <= 2'd1;
               end else if (su_done) begin
                  sn_ff <= su_res[31:0];
                  su_a <= (64'd1 << 60) - 64'(su_res[31:0]) * 64'(su_res[31:0]);
                  su_div <= 1'b0; su_go <= 1'b1;
                  st_ff <= S_SQ3;
               end
            end
            S_SQ3: if (su_done) begin
               cs_ff <= su_res[31:0];
               if (neg_ff) sn_ff <= -sn_ff;
               cstep_ff <= 2'd0;
               st_ff <= S_COEF;
            end
            S_COEF: begin
               logic signed [95:0] m;
               case (cstep_ff)
                  2'd0: begin m = 96'(cs_ff) * 96'(cs_ff); cc_ff <= 32'(rnd30(m)); end
                  2'd1: begin m = 96'(sn_ff) * 96'(sn_ff); ss_ff <= 32'(rnd30(m)); end
                  default: begin
                     m = 96'(sn_ff) * 96'(cs_ff);
                     sc2_ff <= 32'(rnd30(m <<< 1));
                  end
               endcase
               cstep_ff <= cstep_ff + 2'd1;
               if (cstep_ff == 2'd2) begin
                  na_ff <= a_ff; nx_ff <= x_ff;
                  ustep_ff <= '0; wstep_ff <= '0;
                  st_ff <= S_UPD;
               end
            end
            S_UPD: begin
               // products are registered and land in the cycle after their step is issued
               if (ustep_ff != 5'd15) ustep_ff <= ustep_ff + 5'd1;
               if (ustep_ff != 5'd0) begin
                  logic signed [95:0] s;
                  s = 96'(prod_a) + 96'(prod_b);
                  wstep_ff <= wstep_ff + 5'd1;
                  case (wstep_ff)
                     5'd0, 5'd2: acc_ff <= s;
                     5'd1: na_ff[p_ff][p_ff] <= sat(rnd30(acc_ff - 96'(prod_a)));
                     5'd3: na_ff[q_ff][q_ff] <= sat(rnd30(acc_ff + 96'(prod_a)));
                     5'd4: na_ff[p_ff][rr] <= sat(rnd30(s));
                     5'd5: na_ff[q_ff][rr] <= sat(rnd30(s));
                     5'd6: na_ff[rr][p_ff] <= sat(rnd30(s));
                     5'd7: na_ff[rr][q_ff] <= sat(rnd30(s));
                     5'd8, 5'd10, 5'd12: nx_ff[2'(wstep_ff[2:1])][p_ff] <= sat(rnd30(s));
                     5'd9, 5'd11, 5'd13: nx_ff[2'(wstep_ff[2:1])][q_ff] <= sat(rnd30(s));
                     default: begin
                        logic signed [31:0] nz [3][3];
                        nz = na_ff;
                        nz[p_ff][q_ff] = '0;
                        nz[q_ff][p_ff] = '0;
                        a_ff <= nz;
                        x_ff <= nx_ff;
                        k_ff <= k_ff + 8'd1;
                        st_ff <= S_LANE;
                     end
                  endcase
               end
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_column_index <= oc_ff;
               rsp_eigen_value <= a_ff[oc_ff][oc_ff];
               rsp_vec_x <= x_ff[0][oc_ff];
               rsp_vec_y <= x_ff[1][oc_ff];
               rsp_vec_z <= x_ff[2][oc_ff];
               rsp_status <= status_ff;
               rsp_last <= (oc_ff == 2'd2);
               oc_ff <= oc_ff + 2'd1;
               if (oc_ff == 2'd2) st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 3x3 jacobi eigen solver: matrices go in through
// a queue-fed driver, an in-bench fixed-point solver predicts the three
// eigenpairs and a monitor checks every result field by field
// ----------------------------------------------------------------------------
module testbench;
   import jac_pkg::*;

   localparam int  PERIOD = 10;
   localparam longint LIMIT = 8_000_000;

   typedef logic [8:0][31:0] matrix_type;

   typedef struct {
      logic [1:0]         column;
      logic signed [31:0] eigen;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic               status;
      logic               last;
   } eigenpair_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [31:0] req_m [9];
   logic               csr_we;
   logic [0:0]         csr_index;
   logic [CSR_W-1:0]   csr_wdata;
   logic               rsp_valid;
   logic [1:0]         rsp_column_index;
   logic signed [31:0] rsp_eigen_value;
   logic signed [31:0] rsp_vec_x;
   logic signed [31:0] rsp_vec_y;
   logic signed [31:0] rsp_vec_z;
   logic               rsp_status;
   logic               rsp_last;

   matrix_type    pending_matrices[$];
   eigenpair_type expected_pairs[$];

   logic [7:0]    rot_limit;
   logic [30:0]   conv_thresh;
   int            idle_pct;
   int            errors;
   int            n_items;
   int            n_results;
   int            n_converged;
   int            n_limited;
   longint        cycles;

   jacobi_eigen_3x3 i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_m00          (req_m[0]),
      .req_m01          (req_m[1]),
      .req_m02          (req_m[2]),
      .req_m10          (req_m[3]),
      .req_m11          (req_m[4]),
      .req_m12          (req_m[5]),
      .req_m20          (req_m[6]),
      .req_m21          (req_m[7]),
      .req_m22          (req_m[8]),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_column_index (rsp_column_index),
      .rsp_eigen_value  (rsp_eigen_value),
      .rsp_vec_x        (rsp_vec_x),
      .rsp_vec_y        (rsp_vec_y),
      .rsp_vec_z        (rsp_vec_z),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- solver
   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint round_q30(longint v);
      longint unsigned m;
      longint unsigned r;
      m = (v < 0) ? 64'd0 - longint'(v) : longint'(v);
      r = (m + (64'd1 << 29)) >> 30;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic longint turn(longint a, longint ca, longint b, longint cb);
      return clip32(round_q30(a * ca + b * cb));
   endfunction

   function automatic void solve_eigenpairs(matrix_type mt);
      longint a[3][3];
      longint x[3][3];
      longint na[3][3];
      longint nx[3][3];
      longint unsigned best, sa, tb, rr, v, sn, cs;
      longint sns, csv, cc, ss, sc2, app, aqq, apq, sv, tv;
      int p, q, r, k;
      logic stat;
      eigenpair_type e;
      p = 0;
      q = 0;
      k = 0;
      stat = 1'b1;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            a[i][j] = longint'($signed(mt[i * 3 + j]));
            x[i][j] = (i == j) ? 64'sd16777216 : 64'sd0;
         end
      while (k < int'(rot_limit)) begin
         best = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               if (i != j && abs64(a[i][j]) > best) begin
                  best = abs64(a[i][j]);
                  p = i;
                  q = j;
               end
         if (best == 0 || best < longint'(conv_thresh)) begin
            stat = 1'b0;
            break;
         end
         app = a[p][p];
         aqq = a[q][q];
         apq = a[p][q];
         sv = -2 * apq;
         tv = app - aqq;
         sa = abs64(sv);
         tb = abs64(tv);
         while (sa >= (64'd1 << 31) || tb >= (64'd1 << 31)) begin
            sa = sa >> 1;
            tb = tb >> 1;
         end
         rr = int_sqrt(sa * sa + tb * tb);
         if (rr == 0) rr = 1;
         v = (tb << 30) / rr;
         if (v > (64'd1 << 30)) v = 64'd1 << 30;
         sn = int_sqrt(((64'd1 << 30) - v) << 29);
         cs = int_sqrt((64'd1 << 60) - sn * sn);
         sns = (sv != 0 && tv != 0 && ((sv < 0) != (tv < 0))) ? -longint'(sn) : longint'(sn);
         csv = longint'(cs);
         cc = round_q30(csv * csv);
         ss = round_q30(sns * sns);
         sc2 = round_q30(2 * sns * csv);
         na = a;
         na[p][p] = clip32(round_q30(app * cc + aqq * ss - apq * sc2));
         na[q][q] = clip32(round_q30(app * ss + aqq * cc + apq * sc2));
         na[p][q] = 0;
         na[q][p] = 0;
         r = 3 - p - q;
         na[p][r] = turn(a[p][r], csv, a[q][r], -sns);
         na[q][r] = turn(a[q][r], csv, a[p][r], sns);
         na[r][p] = turn(a[r][p], csv, a[r][q], -sns);
         na[r][q] = turn(a[r][q], csv, a[r][p], sns);
         nx = x;
         for (int i = 0; i < 3; i++) begin
            nx[i][p] = turn(x[i][p], csv, x[i][q], -sns);
            nx[i][q] = turn(x[i][q], csv, x[i][p], sns);
         end
         a = na;
         x = nx;
         k++;
      end
      if (stat) n_limited++;
      else n_converged++;
      for (int j = 0; j < 3; j++) begin
         e.column = j[1:0];
         e.eigen  = a[j][j][31:0];
         e.vx     = x[0][j][31:0];
         e.vy     = x[1][j][31:0];
         e.vz     = x[2][j][31:0];
         e.status = stat;
         e.last   = (j == 2);
         expected_pairs.push_back(e);
      end
   endfunction

   // ------------------------------------------------------- driver / monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && start && !busy) begin
         solve_eigenpairs(pending_matrices[0]);
         pending_matrices.pop_front();
         n_items++;
      end
   end

   always @(negedge clock) begin
      if (!reset && pending_matrices.size() > 0 && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         for (int k = 0; k < 9; k++) req_m[k] <= pending_matrices[0][k];
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      eigenpair_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected result column %0d", $time, rsp_column_index);
            errors++;
         end else begin
            e = expected_pairs.pop_front();
            if (rsp_column_index !== e.column || rsp_eigen_value !== e.eigen ||
                rsp_vec_x !== e.vx || rsp_vec_y !== e.vy || rsp_vec_z !== e.vz ||
                rsp_status !== e.status || rsp_last !== e.last) begin
               $display("%0t: mismatch exp col=%0d ev=%h v=%h %h %h st=%b last=%b",
                        $time, e.column, e.eigen, e.vx, e.vy, e.vz, e.status, e.last);
               $display("%0t:          got col=%0d ev=%h v=%h %h %h st=%b last=%b",
                        $time, rsp_column_index, rsp_eigen_value, rsp_vec_x, rsp_vec_y,
                        rsp_vec_z, rsp_status, rsp_last);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic drain();
      while (pending_matrices.size() > 0 || expected_pairs.size() > 0 || start || busy)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_ROT) rot_limit = val[7:0];
      else conv_thresh = val[30:0];
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $signed($urandom) >>> $urandom_range(4, 20);
         2:       return $signed($urandom) >>> 8;
         3:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return $signed($urandom) >>> $urandom_range(2, 10);
      endcase
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type m;
      for (int k = 0; k < 9; k++) m[k] = rand_elem();
      // mostly symmetric, the rest left as drawn
      if ($urandom_range(99) < 80) begin
         m[3] = m[1];
         m[6] = m[2];
         m[7] = m[5];
      end
      if ($urandom_range(9) == 0) m[$urandom_range(1, 2)] = 0;
      return m;
   endfunction

   function automatic matrix_type make_sym(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
                                           logic [31:0] o01, logic [31:0] o02,
                                           logic [31:0] o12);
      matrix_type m;
      m[0] = d0;  m[1] = o01; m[2] = o02;
      m[3] = o01; m[4] = d1;  m[5] = o12;
      m[6] = o02; m[7] = o12; m[8] = d2;
      return m;
   endfunction

   task automatic run_random(int count, int idle);
      idle_pct = idle;
      for (int n = 0; n < count; n++) pending_matrices.push_back(rand_matrix());
      drain();
   endtask

   initial begin
      matrix_type m;
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_ROT;
      csr_wdata = '0;
      for (int k = 0; k < 9; k++) req_m[k] = '0;
      rot_limit = 8'd20;
      conv_thresh = 31'd17;
      idle_pct = 0;
      errors = 0;
      n_items = 0;
      n_results = 0;
      n_converged = 0;
      n_limited = 0;
      cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed matrices on reset settings
      pending_matrices.push_back(make_sym(0, 0, 0, 0, 0, 0));
      pending_matrices.push_back(make_sym(32'h01000000, 32'h01000000, 32'h01000000, 0, 0, 0));
      pending_matrices.push_back(make_sym(32'h03000000, 32'hff000000, 32'h00800000, 0, 0, 0));
      pending_matrices.push_back(make_sym(32'h02000000, 32'h01000000, 32'h03000000,
                                          32'h00800000, 32'h00400000, 32'h00200000));
      // equal off-diagonal magnitudes, first in row order wins
      pending_matrices.push_back(make_sym(32'h01000000, 32'h02000000, 32'h03000000,
                                          32'h00400000, 32'hffc00000, 32'h00400000));
      pending_matrices.push_back(make_sym(32'h01000000, 32'h01000000, 32'h01000000,
                                          32'h00400000, 32'h00400000, 32'h00400000));
      pending_matrices.push_back({9{32'h7fffffff}});
      pending_matrices.push_back({9{32'h80000000}});
      pending_matrices.push_back(make_sym(32'h7fffffff, 32'h80000000, 0,
                                          32'h7fffffff, 32'h80000000, 32'h7fffffff));
      pending_matrices.push_back(make_sym(32'h80000000, 32'h7fffffff, 32'h80000000,
                                          32'h80000000, 32'h7fffffff, 32'h80000000));
      // off-diagonal just around the threshold
      pending_matrices.push_back(make_sym(32'h01000000, 0, 0, 32'd16, 0, 0));
      pending_matrices.push_back(make_sym(32'h01000000, 0, 0, 32'd17, 0, 0));
      // equal diagonals so the angle is a plain 45 degrees
      pending_matrices.push_back(make_sym(32'h01000000, 32'h01000000, 0, 32'h00100000, 0, 0));
      // asymmetric
      m = make_sym(32'h01000000, 32'h02000000, 32'hfe000000, 32'h00300000, 0, 32'h00050000);
      m[3] = 32'hff700000;
      m[7] = 32'h00900000;
      pending_matrices.push_back(m);
      m = '0;
      m[6] = 32'h7fffffff;
      pending_matrices.push_back(m);
      for (int n = 0; n < 5; n++) pending_matrices.push_back(rand_matrix());
      drain();

      // zero rotation limit and zero threshold
      write_csr(CSR_MAX_ROT, 31'd0);
      write_csr(CSR_THRESH, 31'd0);
      pending_matrices.push_back(make_sym(32'h01000000, 0, 32'hff000000, 32'h00100000, 0, 0));
      pending_matrices.push_back(rand_matrix());
      drain();
      write_csr(CSR_MAX_ROT, 31'd1);
      pending_matrices.push_back(make_sym(0, 0, 0, 0, 0, 0));
      pending_matrices.push_back(rand_matrix());
      drain();

      // widest threshold: only off-diagonals of magnitude 2^31 - 1 or more rotate
      write_csr(CSR_MAX_ROT, 31'd255);
      write_csr(CSR_THRESH, 31'h7fffffff);
      run_random(4, 0);
      // longest limit with a tight bound, only a couple of items
      write_csr(CSR_THRESH, 31'd1);
      run_random(2, 0);

      // random phases over several settings and idling patterns
      write_csr(CSR_MAX_ROT, 31'd20);
      write_csr(CSR_THRESH, 31'd17);
      run_random(40, 0);
      write_csr(CSR_MAX_ROT, 31'($urandom_range(1, 4)));
      write_csr(CSR_THRESH, 31'($urandom_range(1, 31'h00ffffff)));
      run_random(50, 69);
      write_csr(CSR_MAX_ROT, 31'($urandom_range(2, 10)));
      write_csr(CSR_THRESH, 31'h00010000);
      run_random(50, 0);
      write_csr(CSR_MAX_ROT, 31'd1);
      write_csr(CSR_THRESH, 31'($urandom));
      run_random(45, 19);
      write_csr(CSR_MAX_ROT, 31'($urandom_range(3, 12)));
      write_csr(CSR_THRESH, 31'($urandom_range(1, 4096)));
      run_random(50, 69);
      write_csr(CSR_MAX_ROT, 31'd6);
      write_csr(CSR_THRESH, 31'h7fffffff);
      run_random(20, 19);
      write_csr(CSR_MAX_ROT, 31'd8);
      write_csr(CSR_THRESH, 31'd1);
      run_random(25, 0);

      repeat (50) @(negedge clock);
      $display("ran %0d matrices, checked %0d eigenpairs (%0d converged, %0d at the limit)",
               n_items, n_results, n_converged, n_limited);
      $display("rotation limits 0 to 255, thresholds 0 to max, idle 0/19/69 percent");
      if (errors == 0 && expected_pairs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors, %0d results missing", errors, expected_pairs.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ jacobi_eigen_3x3.f @@
hw/rtl/jac_pkg.sv
hw/rtl/jac_lane.sv
hw/rtl/jac_merge.sv
hw/rtl/jac_sqrt.sv
hw/rtl/jacobi_eigen_3x3.sv
verif/testbench.sv
